/* hw/rtl/assert_macros.svh */
// Assertion helpers; the using module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CLE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cle_pkg.sv */
package cle_pkg;

  localparam int LINE_LEN = 32;
  localparam int ADDR_W   = $clog2(LINE_LEN);
  localparam int FILL_W   = $clog2(LINE_LEN + 1);
  localparam int LIM_W    = 6;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(32);
  localparam logic             REG_IDX_LIMIT = 1'b0;

  localparam logic [7:0] CH_EOF    = 8'd4;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_KILL   = 8'd21;
  localparam logic [7:0] CH_WERASE = 8'd23;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_INTR   = 8'd127;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_INTR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO,
    ST_BS,
    ST_KILL,
    ST_WRD,
    ST_WEMIT,
    ST_INTR,
    ST_EMPTY,
    ST_DRD,
    ST_DEMIT
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic              idle;
    logic [FILL_W-1:0] fill;
  } sts_t;

endpackage

/* hw/rtl/cle_line_ram.sv */
module cle_line_ram
  import cle_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [LINE_LEN];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/cle_seq.sv */
module cle_seq
  import cle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic [LIM_W-1:0] limit,
  input  logic [7:0]       rd_data,
  input  logic             res_ready,
  output logic             res_valid,
  output res_t             res,
  output ram_req_t         ram_req,
  output sts_t             sts
);

  state_t            state_r, state_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  logic [LIM_W-1:0]  eff_limit;
  logic              accept, fire, fill_zero, fill_one, room, dlv, stop, dlast;
  logic [FILL_W-1:0] fill_dec, fill_after;

  always_comb begin
    priority if (limit == '0) begin
      eff_limit = LIM_W'(1);
    end else if (limit > LIM_W'(LINE_LEN)) begin
      eff_limit = LIM_W'(LINE_LEN);
    end else begin
      eff_limit = limit;
    end
  end

  assign accept     = (state_r == ST_IDLE) && in_valid;
  assign fire       = res_valid && res_ready;
  assign fill_zero  = (fill_r == '0);
  assign fill_one   = (fill_r == FILL_W'(1));
  assign fill_dec   = fill_r - FILL_W'(1);
  assign room       = (fill_r < FILL_W'(LINE_LEN));
  assign fill_after = fill_r + FILL_W'(room);
  assign dlv        = (byte_r == CH_NL) || (fill_after >= FILL_W'(eff_limit));
  assign stop       = (rd_data == CH_SPACE) || (rd_data == CH_TAB) || fill_one;
  assign dlast      = (FILL_W'(idx_r) + FILL_W'(1)) == fill_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_byte)
            CH_EOF:    state_nxt = fill_zero ? ST_EMPTY : ST_DRD;
            CH_BS:     state_nxt = fill_zero ? ST_IDLE : ST_BS;
            CH_KILL:   state_nxt = fill_zero ? ST_IDLE : ST_KILL;
            CH_WERASE: state_nxt = fill_zero ? ST_IDLE : ST_WRD;
            CH_INTR:   state_nxt = ST_INTR;
            default:   state_nxt = ST_ECHO;
          endcase
        end
      end
      ST_ECHO:  if (fire) state_nxt = dlv ? ST_DRD : ST_IDLE;
      ST_BS:    if (fire) state_nxt = ST_IDLE;
      ST_KILL:  if (fire && fill_one) state_nxt = ST_IDLE;
      ST_WRD:   state_nxt = ST_WEMIT;
      ST_WEMIT: if (fire) state_nxt = stop ? ST_IDLE : ST_WRD;
      ST_INTR:  if (fire) state_nxt = ST_EMPTY;
      ST_EMPTY: if (fire) state_nxt = ST_IDLE;
      ST_DRD:   state_nxt = ST_DEMIT;
      ST_DEMIT: if (fire) state_nxt = dlast ? ST_IDLE : ST_DRD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = KIND_ECHO;
    res.data        = CH_BS;
    res.last        = 1'b1;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = fill_r[ADDR_W-1:0];
    ram_req.wr_data = byte_r;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = idx_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_ECHO: begin
        res_valid     = 1'b1;
        res.data      = byte_r;
        res.last      = !dlv;
        ram_req.wr_en = fire && room;
      end
      ST_BS:   res_valid = 1'b1;
      ST_KILL: begin
        res_valid = 1'b1;
        res.last  = fill_one;
      end
      ST_WRD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = fill_dec[ADDR_W-1:0];
      end
      ST_WEMIT: begin
        res_valid = 1'b1;
        res.last  = stop;
      end
      ST_INTR: begin
        res_valid = 1'b1;
        res.kind  = KIND_INTR;
        res.data  = '0;
        res.last  = 1'b0;
      end
      ST_EMPTY: begin
        res_valid = 1'b1;
        res.kind  = KIND_EMPTY;
        res.data  = '0;
      end
      ST_DRD:  ram_req.rd_en = 1'b1;
      ST_DEMIT: begin
        res_valid = 1'b1;
        res.kind  = KIND_LINE;
        res.data  = rd_data;
        res.last  = dlast;
      end
      default: ;
    endcase
  end

  // line bookkeeping
  always_comb begin
    byte_nxt = accept ? in_byte : byte_r;
    fill_nxt = fill_r;
    idx_nxt  = accept ? '0 : idx_r;
    if (fire) begin
      unique case (state_r)
        ST_ECHO:                     fill_nxt = fill_after;
        ST_BS, ST_KILL, ST_WEMIT:    fill_nxt = fill_dec;
        ST_INTR, ST_EMPTY:           fill_nxt = '0;
        ST_DEMIT: begin
          if (dlast) begin
            fill_nxt = '0;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    idx_r  <= idx_nxt;
  end

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.fill = fill_r;

endmodule

/* hw/rtl/cle_out_reg.sv */
module cle_out_reg
  import cle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  input  res_t res,
  output logic res_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r, valid_nxt;
  res_t res_r, res_nxt;

  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* hw/rtl/cooked_line_editor_top.sv */
// Cooked line editor: canonical-mode console line discipline.
// Input: one raw console byte per transfer on in_valid/in_ready.
// Output: zero or more results per byte on out_valid/out_ready, each with
//   out_kind (echo, line byte, empty delivery, interrupt), out_byte and
//   out_last, which marks the final result of that input byte.
// Config: APB-style port, line_limit at address 0; pready is tied high.
// Sequencing: a byte is taken only while the sequencer is idle. Backspace
//   and kill give one echo per erased byte; word erase and line delivery
//   read the line RAM before each result. A plain byte's echo passes through
//   the sequencer state register and the output register to out_valid.
// Results pass through a one-entry output register, so a new byte can be
//   taken while the last result waits. A stall on out_ready holds the
//   sequencer on its current result; nothing is lost or repeated.
// Reset (rst_n, synchronous): empty line, no pending result, line_limit 32.
//   The line RAM is not cleared; only entries below the fill are read.
`include "assert_macros.svh"

module cooked_line_editor_top
  import cle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [LIM_W-1:0] limit_r, limit_nxt;
  logic             limit_sel;
  logic [7:0]       rd_data;
  logic             res_valid, res_ready;
  res_t             res, out_res;
  ram_req_t         ram_req;
  sts_t             sts;

  assign pready    = 1'b1;
  assign limit_sel = (paddr[CFG_AW-1] == REG_IDX_LIMIT);

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && limit_sel) begin
      limit_nxt = pwdata[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign prdata = limit_sel ? CFG_DW'(limit_r) : '0;

  cle_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .limit     (limit_r),
    .rd_data   (rd_data),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .ram_req   (ram_req),
    .sts       (sts)
  );

  cle_line_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  cle_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign in_ready = sts.idle;
  assign out_kind = out_res.kind;
  assign out_byte = out_res.data;
  assign out_last = out_res.last;

  `CLE_ASSERT(a_fill_bound, sts.fill <= FILL_W'(LINE_LEN), "fill beyond line length")
  `CLE_ASSERT(a_idle_quiet, sts.idle |-> !res_valid, "result offered while idle")
  `CLE_ASSERT(a_kind_zero,
              out_valid && (out_kind == KIND_EMPTY || out_kind == KIND_INTR) |-> out_byte == '0,
              "non-zero byte on empty or interrupt result")
  `CLE_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  localparam int SETTLE_CYC = 80;
  localparam int HOLD_CYC   = 200;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [7:0]        in_byte   = '0;
  logic              out_ready = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic              in_ready;
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [7:0]        out_byte;
  logic              out_last;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  cooked_line_editor_top dut (.*);

  // shadow of the line discipline
  logic [7:0]       line_copy [LINE_LEN];
  int unsigned      line_fill = 0;
  logic [LIM_W-1:0] limit_copy = LIMIT_RST;
  res_t             step_results[$];
  res_t             pending_results[$];

  int errors       = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int limits_used  = 1;
  bit gaps_on      = 1'b0;
  bit stall_on     = 1'b0;
  bit hold_req     = 1'b0;

  initial forever #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void push_res(input kind_t k, input logic [7:0] b);
    step_results.push_back('{k, b, 1'b0});
  endfunction

  function automatic void deliver_line();
    if (line_fill == 0) begin
      push_res(KIND_EMPTY, 8'h00);
    end else begin
      for (int i = 0; i < line_fill; i++) push_res(KIND_LINE, line_copy[i]);
    end
    line_fill = 0;
  endfunction

  function automatic void edit_line(input logic [7:0] c);
    res_t        r;
    int unsigned lim;
    logic [7:0]  popped;
    step_results.delete();
    lim = (limit_copy == 0) ? 1 : ((limit_copy > LINE_LEN) ? LINE_LEN : limit_copy);
    case (c)
      CH_EOF: deliver_line();
      CH_BS: begin
        if (line_fill > 0) begin
          push_res(KIND_ECHO, CH_BS);
          line_fill--;
        end
      end
      CH_KILL: begin
        while (line_fill > 0) begin
          push_res(KIND_ECHO, CH_BS);
          line_fill--;
        end
      end
      CH_WERASE: begin
        while (line_fill > 0) begin
          line_fill--;
          popped = line_copy[line_fill];
          push_res(KIND_ECHO, CH_BS);
          if (popped == CH_SPACE || popped == CH_TAB) break;
        end
      end
      CH_INTR: begin
        line_fill = 0;
        push_res(KIND_INTR, 8'h00);
        push_res(KIND_EMPTY, 8'h00);
      end
      default: begin
        push_res(KIND_ECHO, c);
        if (line_fill < LINE_LEN) begin
          line_copy[line_fill] = c;
          line_fill++;
        end
        if (c == CH_NL || line_fill >= lim) deliver_line();
      end
    endcase
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      r.last = (i == step_results.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  function automatic logic [7:0] console_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(33, 126));
    if (r < 63) return CH_SPACE;
    if (r < 67) return CH_TAB;
    if (r < 73) return CH_BS;
    if (r < 77) return CH_WERASE;
    if (r < 79) return CH_KILL;
    if (r < 84) return CH_NL;
    if (r < 87) return CH_EOF;
    if (r < 89) return CH_INTR;
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: random stall bursts, or one long hold on request
  initial forever begin
    @(posedge clk);
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYC) @(posedge clk);
      hold_req = 1'b0;
      out_ready <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%t: result with nothing expected: kind %0d byte %h last %b",
                 $time, out_kind, out_byte, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) begin
          errors++;
          $display("%t: kind expected %0d actual %0d", $time, want.kind, out_kind);
        end
        if (out_byte !== want.data) begin
          errors++;
          $display("%t: byte expected %h actual %h", $time, want.data, out_byte);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%t: last expected %b actual %b", $time, want.last, out_last);
        end
      end
    end
  end

  task automatic type_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    edit_line(b);
    bytes_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIM_W-1:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * REG_IDX_LIMIT);
    pwdata  <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_copy = v;
    limits_used++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LIM_W-1:0] !== v) begin
      errors++;
      $display("%t: line_limit readback expected %0d actual %0d",
               $time, v, prdata[LIM_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_editing();
    logic [7:0] seq [] = '{CH_BS, CH_KILL, CH_WERASE, CH_EOF, 8'h00, 8'hFF, CH_BS,
                           8'h61, CH_SPACE, 8'h62, CH_TAB, 8'h63, CH_WERASE,
                           CH_WERASE, CH_KILL, 8'h78, 8'h79, CH_EOF, 8'h7A, CH_INTR,
                           8'h68, 8'h69, CH_NL};
    foreach (seq[i]) type_byte(seq[i]);
  endtask

  task automatic test_limits();
    set_limit(6'd1);
    type_byte(8'h71);
    type_byte(8'h72);
    set_limit(6'd0);
    type_byte(CH_BS);
    type_byte(8'h73);
    set_limit(6'd32);
    type_byte(8'h77);
    type_byte(8'h6F);
    type_byte(8'h72);
    type_byte(8'h64);
    // limit now below the fill: next stored byte delivers everything
    set_limit(6'd2);
    type_byte(8'h21);
  endtask

  task automatic test_backpressure();
    set_limit(6'd63);
    hold_req = 1'b1;
    repeat (LINE_LEN) type_byte(8'($urandom_range(33, 126)));
  endtask

  task automatic test_random(input logic [LIM_W-1:0] lim, input int n);
    set_limit(lim);
    repeat (n) type_byte(console_byte());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_editing();
    test_limits();
    test_backpressure();
    test_random(6'd20, 27);
    test_random(6'd3, 27);
    test_random(6'd7, 27);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random(6'd32, 27);
    settle();
    $display("%0d console bytes typed, %0d results checked", bytes_sent, results_seen);
    $display("%0d line_limit settings incl. 0, 1 and 63; editing keys, EOF, interrupt",
             limits_used);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
